// ----- hw/rtl/gfr_pkg.sv -----
package gfr_pkg;

	// item kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_TIMEOUT_LIMIT = 1'b0,
		CFG_SYNC_BYTE     = 1'b1
	} cfg_reg_t;

	localparam logic [15:0] TIMEOUT_LIMIT_RST = 16'd200;
	localparam logic [7:0]  SYNC_BYTE_RST     = 8'hAA;
	localparam logic [15:0] IDLE_WORD         = 16'hFFFF;
	// buttons with bits 1 and 3 low
	localparam logic [15:0] RESET_COMBO       = 16'hFFF5;
	localparam logic [7:0]  SYNC_TARGET       = 8'd4;
	localparam logic [2:0]  LAST_SLOT         = 3'd5;
	localparam int          SLOTS             = 6;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [15:0] buttons;
		logic [15:0] left_stick;
		logic [15:0] right_stick;
		logic        frame_done;
		logic        timed_out;
		logic        reset_request;
	} out_item_t;

	typedef struct packed {
		cfg_reg_t    idx;
		logic [15:0] wdata;
	} cfg_req_t;

endpackage

// ----- hw/rtl/gfr_stream_if.sv -----
interface gfr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/gamepad_frame_receiver_with_timeout.sv -----
// Gamepad frame receiver with timeout. Requests on "in" are either a received
// serial byte (kind 0) or a timer tick (kind 1); every request yields exactly one
// response on "out" carrying the latched buttons, right stick and left stick
// words plus three flags. Four consecutive sync bytes (cfg register 1) open a
// six-byte payload; the sixth payload byte latches the words, clears the sync
// count and the idle counter and raises frame_done. Ticks advance a 16-bit idle
// counter; once it is above timeout_limit (cfg register 0) all words read 0xFFFF
// and timed_out is set. reset_request flags a tick whose buttons word is 0xFFF5.
// Throughput is one request per clock while the consumer takes responses; a
// response passes the input register, then the result register, before it is
// valid on "out". The state update is a single combinational pass in the
// compute stage, which sets that rate. A full output register only stalls the
// input when the consumer holds off. No clearing pass after reset. Config writes
// are always ready and must only happen while idle.
module gamepad_frame_receiver_with_timeout (
	input logic          clk,
	input logic          arst_n,
	gfr_stream_if.sink   in,
	gfr_stream_if.source out,
	gfr_stream_if.sink   cfg
);
	import gfr_pkg::*;

	// config registers
	logic [15:0] timeout_limit_q;
	logic [7:0]  sync_byte_q;

	// receiver state
	logic [7:0]  sync_q;
	logic [2:0]  idx_q;
	logic [15:0] idle_q;
	logic [15:0] btn_q, left_q, right_q;
	// payload bytes 0..4; byte 5 is taken straight from the request
	logic [7:0]  store_q [SLOTS-1];

	// input register
	logic     vld_s1;
	in_item_t item_s1;

	// result register
	logic      out_vld_q;
	out_item_t out_q;

	logic advance;

	// next-state values
	logic [7:0]  sync_mid, sync_n;
	logic [2:0]  idx_inc, idx_n;
	logic [15:0] idle_inc, idle_n;
	logic [15:0] btn_n, left_n, right_n;
	logic        done, tout, rreq, store_we;

	assign advance   = vld_s1 && (!out_vld_q || out.ready);
	assign in.ready  = !vld_s1 || advance;
	assign cfg.ready = 1'b1;
	assign out.valid = out_vld_q;
	assign out.data  = out_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_limit_q <= TIMEOUT_LIMIT_RST;
			sync_byte_q     <= SYNC_BYTE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.data.idx)
				CFG_TIMEOUT_LIMIT: timeout_limit_q <= cfg.data.wdata;
				CFG_SYNC_BYTE:     sync_byte_q     <= cfg.data.wdata[7:0];
				default:           ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in.ready) begin
			vld_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.ready && in.valid) begin
			item_s1 <= in.data;
		end
	end

	// single-pass update for the registered request
	always_comb begin
		sync_mid = sync_q;
		sync_n   = sync_q;
		idx_inc  = idx_q + 3'd1;
		idx_n    = idx_q;
		idle_inc = idle_q + 16'd1;
		idle_n   = idle_q;
		btn_n    = btn_q;
		left_n   = left_q;
		right_n  = right_q;
		done     = 1'b0;
		tout     = 1'b0;
		rreq     = 1'b0;
		store_we = 1'b0;
		if (item_s1.kind == KIND_BYTE) begin
			if (sync_q == SYNC_TARGET) begin
				store_we = (idx_q < LAST_SLOT);
				if (idx_inc > LAST_SLOT) begin
					// sixth payload byte: latch the frame
					done     = 1'b1;
					sync_mid = 8'd0;
					idx_n    = 3'd0;
					idle_n   = 16'd0;
					btn_n    = {store_q[0], store_q[1]};
					right_n  = {store_q[2], store_q[3]};
					left_n   = {store_q[4], item_s1.rx_byte};
				end else begin
					idx_n = idx_inc;
				end
			end
			// sync counting runs after the payload step; index is kept on lost sync
			if (item_s1.rx_byte == sync_byte_q) begin
				sync_n = sync_mid + 8'd1;
			end else if (sync_mid != SYNC_TARGET) begin
				sync_n = 8'd0;
			end else begin
				sync_n = sync_mid;
			end
		end else begin
			idle_n = idle_inc;
			if (idle_inc > timeout_limit_q) begin
				btn_n   = IDLE_WORD;
				left_n  = IDLE_WORD;
				right_n = IDLE_WORD;
				tout    = 1'b1;
			end
			rreq = (btn_n == RESET_COMBO);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q  <= 8'd0;
			idx_q   <= 3'd0;
			idle_q  <= 16'd0;
			btn_q   <= IDLE_WORD;
			left_q  <= IDLE_WORD;
			right_q <= IDLE_WORD;
		end else if (advance) begin
			sync_q  <= sync_n;
			idx_q   <= idx_n;
			idle_q  <= idle_n;
			btn_q   <= btn_n;
			left_q  <= left_n;
			right_q <= right_n;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && store_we) begin
			store_q[idx_q] <= item_s1.rx_byte;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (out.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.buttons       <= btn_n;
			out_q.left_stick    <= left_n;
			out_q.right_stick   <= right_n;
			out_q.frame_done    <= done;
			out_q.timed_out     <= tout;
			out_q.reset_request <= rreq;
		end
	end

`ifndef SYNTH
	// index only ever walks 0..5
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_SLOT)
		else $error("payload index out of range");

	// a response is either a frame or a tick result, never both
	a_flag_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !(out_q.frame_done && (out_q.timed_out || out_q.reset_request)))
		else $error("byte and tick flags together");

	a_timeout_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.timed_out) |-> (out_q.buttons == IDLE_WORD &&
			out_q.left_stick == IDLE_WORD && out_q.right_stick == IDLE_WORD))
		else $error("timeout without idle words");

	// a completed frame restarts sync and idle counting
	a_frame_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && done) |=> (idle_q == 16'd0 && idx_q == 3'd0 && sync_q <= 8'd1))
		else $error("frame completion did not clear counters");

	// a stalled response is not overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out.ready) |=> (out_vld_q && $stable(out_q)))
		else $error("stalled response changed");
`endif

endmodule
